@@ hdl/bhpq_pkg.sv @@
package bhpq_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CAPACITY   = 1024;
    localparam int FILL_WIDTH = 11;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                          kind;
        logic signed [DATA_WIDTH-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  result_value;
        logic [1:0]                    status;
        logic [FILL_WIDTH-1:0]         fill_count;
    } t_out_item;

    function automatic logic sorts_first(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b,
        input logic                         min_order
    );
        return min_order ? (a > b) : (a < b);
    endfunction

endpackage

@@ hdl/bhpq_ram.sv @@
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ hdl/bhpq_ctrl.sv @@
module bhpq_ctrl #(
    parameter int CAPACITY = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_min_order,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  bhpq_pkg::t_in_item          i_item,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output bhpq_pkg::t_out_item         o_res,
    output logic                        o_we,
    output logic [$clog2(CAPACITY)-1:0] o_waddr,
    output logic [bhpq_pkg::DATA_WIDTH-1:0] o_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_raddr_a,
    output logic [$clog2(CAPACITY)-1:0] o_raddr_b,
    input  logic [bhpq_pkg::DATA_WIDTH-1:0] i_rdata_a,
    input  logic [bhpq_pkg::DATA_WIDTH-1:0] i_rdata_b
);

    import bhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 1;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_UP_CMP  = 3'd1;
    localparam logic [2:0] ST_DN_LOAD = 3'd2;
    localparam logic [2:0] ST_DN_CMP  = 3'd3;
    localparam logic [2:0] ST_WRITE   = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    logic [2:0]                   r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_cur, n_cur;
    logic [XW-1:0]                r_ch, n_ch;
    logic signed [DATA_WIDTH-1:0] r_val, n_val;
    t_out_item                    r_res, n_res;

    logic [CW-1:0]                count_inc;
    logic [CW-1:0]                count_dec;
    logic [CW-1:0]                ins_par;
    logic [CW-1:0]                up_par;
    logic [CW-1:0]                up_gpar;
    logic signed [DATA_WIDTH-1:0] c1;
    logic signed [DATA_WIDTH-1:0] c2;
    logic [XW-1:0]                ch_next;
    logic [XW-1:0]                sel;
    logic signed [DATA_WIDTH-1:0] sel_val;
    logic [XW-1:0]                nch;
    logic [XW-1:0]                nch_b;

    always_comb begin
        count_inc = r_count + CW'(1);
        count_dec = r_count - CW'(1);
        ins_par   = count_dec >> 1;
        up_par    = (r_cur - CW'(1)) >> 1;
        up_gpar   = (up_par - CW'(1)) >> 1;
        c1        = $signed(i_rdata_a);
        c2        = $signed(i_rdata_b);
        ch_next   = r_ch + XW'(1);
        if ((ch_next < XW'(r_count)) && sorts_first(c1, c2, i_min_order)) begin
            sel     = ch_next;
            sel_val = c2;
        end else begin
            sel     = r_ch;
            sel_val = c1;
        end
        nch   = (sel << 1) + XW'(1);
        nch_b = nch + XW'(1);
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cur     = r_cur;
        n_ch      = r_ch;
        n_val     = r_val;
        n_res     = r_res;
        o_we      = 1'b0;
        o_waddr   = r_cur[AW-1:0];
        o_wdata   = r_val;
        o_raddr_a = '0;
        o_raddr_b = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_res.result_value = '0;
                    n_res.status       = STATUS_OK;
                    n_res.fill_count   = FILL_WIDTH'(r_count);
                    if (i_item.kind == KIND_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_res.status = STATUS_FULL;
                            n_state      = ST_DONE;
                        end else begin
                            n_count          = count_inc;
                            n_res.fill_count = FILL_WIDTH'(count_inc);
                            n_val            = i_item.value;
                            n_cur            = r_count;
                            if (r_count == '0) begin
                                o_we    = 1'b1;
                                o_waddr = '0;
                                o_wdata = i_item.value;
                                n_state = ST_DONE;
                            end else begin
                                o_raddr_a = ins_par[AW-1:0];
                                n_state   = ST_UP_CMP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.status = STATUS_EMPTY;
                            n_state      = ST_DONE;
                        end else begin
                            o_raddr_a = '0;
                            o_raddr_b = count_dec[AW-1:0];
                            n_count   = count_dec;
                            n_state   = ST_DN_LOAD;
                        end
                    end
                end
            end
            ST_UP_CMP: begin
                o_we = 1'b1;
                if (sorts_first(c1, r_val, i_min_order)) begin
                    o_wdata = c1;
                    n_cur   = up_par;
                    if (up_par == '0) begin
                        n_state = ST_WRITE;
                    end else begin
                        o_raddr_a = up_gpar[AW-1:0];
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DN_LOAD: begin
                n_val              = c2;
                n_res.result_value = c1;
                n_res.status       = STATUS_OK;
                n_res.fill_count   = FILL_WIDTH'(r_count);
                n_cur              = '0;
                if (r_count == '0) begin
                    n_state = ST_DONE;
                end else if (r_count == CW'(1)) begin
                    n_state = ST_WRITE;
                end else begin
                    o_raddr_a = AW'(1);
                    o_raddr_b = AW'(2);
                    n_ch      = XW'(1);
                    n_state   = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                o_we = 1'b1;
                if (sorts_first(sel_val, r_val, i_min_order)) begin
                    n_state = ST_DONE;
                end else begin
                    o_wdata = sel_val;
                    n_cur   = sel[CW-1:0];
                    if (nch < XW'(r_count)) begin
                        o_raddr_a = nch[AW-1:0];
                        o_raddr_b = nch_b[AW-1:0];
                        n_ch      = nch;
                    end else begin
                        n_state = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                o_we    = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_cur <= n_cur;
        r_ch  <= n_ch;
        r_val <= n_val;
        r_res <= n_res;
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

endmodule

@@ hdl/binary_heap_priority_queue_top.sv @@
// Binary-heap priority queue over signed 32-bit values.
// Input channel (i_in_valid / o_in_ready / i_in_item): kind 0 inserts value,
// kind 1 removes and returns the root. Output channel (o_out_valid /
// i_out_ready / o_out_item): one transaction per input transaction with the
// removed value, a status code and the element count after the operation.
// i_cfg_we / i_cfg_data set min order (0 largest first, 1 smallest first);
// write it only while the block is idle.
// One operation at a time. The heap lives in a dual-read-port RAM with registered
// read data; each heap level costs one RAM round.
// Errors and an insert into an empty heap go from idle straight to the result;
// an insert otherwise moves up one level per RAM round; a removal loads the root
// and the last element, then moves down one level per RAM round (removal of the
// last element ends after the load).
// The result is held in an output register; the next transaction is taken
// in the cycle after the result moves there. If the receiver stalls with the
// output register full, the block holds the next result and stops taking input.
// Reset empties the heap and selects largest-first order; RAM contents are
// not cleared.
module binary_heap_priority_queue_top #(
    parameter int CAPACITY = bhpq_pkg::CAPACITY
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bhpq_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bhpq_pkg::t_out_item  o_out_item
);

    import bhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                  r_min_order;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  res_valid;
    logic                  res_ready;
    t_out_item             res;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr_a;
    logic [AW-1:0]         ram_raddr_b;
    logic [DATA_WIDTH-1:0] ram_rdata_a;
    logic [DATA_WIDTH-1:0] ram_rdata_b;

    assign res_ready = !r_out_valid || i_out_ready;

    bhpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_min_order (r_min_order),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_raddr_a   (ram_raddr_a),
        .o_raddr_b   (ram_raddr_b),
        .i_rdata_a   (ram_rdata_a),
        .i_rdata_b   (ram_rdata_b)
    );

    bhpq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_order <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_order <= i_cfg_data;
            end
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_valid && res_ready) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ tb/testbench.sv @@
module testbench;
    import bhpq_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct packed {
        logic                         kind;
        logic signed [DATA_WIDTH-1:0] value;
        logic                         pinned;
        t_out_item                    want;
    } t_op_row;

    localparam t_op_row OP_ROWS [22] = '{
        '{KIND_REMOVE, 32'sh5A5A5A5A, 1'b1, '{32'sd0, STATUS_EMPTY, 11'd0}},
        '{KIND_INSERT, 32'sh7FFFFFFF, 1'b1, '{32'sd0, STATUS_OK, 11'd1}},
        '{KIND_INSERT, 32'sh80000000, 1'b1, '{32'sd0, STATUS_OK, 11'd2}},
        '{KIND_INSERT, 32'sd0,        1'b1, '{32'sd0, STATUS_OK, 11'd3}},
        '{KIND_INSERT, -32'sd1,       1'b1, '{32'sd0, STATUS_OK, 11'd4}},
        '{KIND_INSERT, 32'sd5,        1'b0, '0},
        '{KIND_INSERT, 32'sd5,        1'b0, '0},
        '{KIND_INSERT, 32'sd5,        1'b0, '0},
        '{KIND_REMOVE, -32'sd1,       1'b1, '{32'sh7FFFFFFF, STATUS_OK, 11'd6}},
        '{KIND_REMOVE, 32'sd0,        1'b0, '0},
        '{KIND_REMOVE, 32'sd0,        1'b0, '0},
        '{KIND_REMOVE, 32'sd0,        1'b0, '0},
        '{KIND_REMOVE, 32'sd0,        1'b0, '0},
        '{KIND_REMOVE, 32'sd0,        1'b0, '0},
        '{KIND_REMOVE, 32'sh7FFFFFFF, 1'b1, '{32'sh80000000, STATUS_OK, 11'd0}},
        '{KIND_REMOVE, 32'sd0,        1'b1, '{32'sd0, STATUS_EMPTY, 11'd0}},
        '{KIND_INSERT, -32'sd7,       1'b0, '0},
        '{KIND_INSERT, -32'sd7,       1'b0, '0},
        '{KIND_INSERT, 32'sd3,        1'b0, '0},
        '{KIND_REMOVE, 32'sd0,        1'b0, '0},
        '{KIND_REMOVE, 32'sd0,        1'b0, '0},
        '{KIND_REMOVE, 32'sd0,        1'b1, '{-32'sd7, STATUS_OK, 11'd0}}
    };

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_data  = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    logic signed [DATA_WIDTH-1:0] heap_mem [CAPACITY];
    int unsigned                  heap_count = 0;
    logic                         order_min  = 1'b0;

    t_out_item due_results [$];
    t_out_item predicted;
    t_out_item oldest;
    logic      pin_on = 1'b0;
    t_out_item pin_want = '0;
    int        errors = 0;
    int        send_quiet = 0;
    int        recv_quiet = 0;

    binary_heap_priority_queue_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic ranks_ahead(input logic signed [DATA_WIDTH-1:0] a,
                                         input logic signed [DATA_WIDTH-1:0] b);
        return order_min ? (a > b) : (a < b);
    endfunction

    function automatic t_out_item heap_apply(input t_in_item op);
        t_out_item                    r;
        int unsigned                  pos;
        int unsigned                  up;
        int unsigned                  kid;
        int unsigned                  n;
        logic signed [DATA_WIDTH-1:0] last;
        logic signed [DATA_WIDTH-1:0] tmp;
        r = '0;
        if (op.kind == KIND_INSERT) begin
            if (heap_count >= CAPACITY) begin
                r.status = STATUS_FULL;
            end else begin
                pos = heap_count;
                heap_mem[pos] = op.value;
                heap_count++;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (!ranks_ahead(heap_mem[up], heap_mem[pos])) break;
                    tmp = heap_mem[up];
                    heap_mem[up] = heap_mem[pos];
                    heap_mem[pos] = tmp;
                    pos = up;
                end
            end
        end else if (heap_count == 0) begin
            r.status = STATUS_EMPTY;
        end else begin
            r.result_value = heap_mem[0];
            last = heap_mem[heap_count - 1];
            heap_count--;
            n = heap_count;
            if (n > 0) begin
                up = 0;
                kid = 1;
                while (kid < n) begin
                    if (kid + 1 < n && ranks_ahead(heap_mem[kid], heap_mem[kid + 1])) kid++;
                    if (ranks_ahead(heap_mem[kid], last)) break;
                    heap_mem[up] = heap_mem[kid];
                    up = kid;
                    kid = 2 * up + 1;
                end
                heap_mem[up] = last;
            end
        end
        r.fill_count = FILL_WIDTH'(heap_count);
        return r;
    endfunction

    function automatic int pick_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 40) == 0) quiet = $urandom_range(10, 40);
        return $urandom_range(0, 7);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return $signed($urandom_range(0, 15)) - 8;
            default: return $signed($urandom);
        endcase
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) order_min = cfg_data;
            if (in_valid && o_in_ready) begin
                predicted = heap_apply(in_item);
                due_results.insert(due_results.size(), pin_on ? pin_want : predicted);
            end
            if (o_out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none actual %p", $time,
                             o_out_item);
                    errors++;
                end else begin
                    oldest = due_results.pop_front();
                    if (o_out_item.result_value !== oldest.result_value) begin
                        $display("%0t: result_value expected %0d actual %0d", $time,
                                 oldest.result_value, o_out_item.result_value);
                        errors++;
                    end
                    if (o_out_item.status !== oldest.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 oldest.status, o_out_item.status);
                        errors++;
                    end
                    if (o_out_item.fill_count !== oldest.fill_count) begin
                        $display("%0t: fill_count expected %0d actual %0d", $time,
                                 oldest.fill_count, o_out_item.fill_count);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        @(posedge rst_n);
        forever begin
            int stall;
            stall = pick_wait(recv_quiet);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!o_out_valid);
            @(negedge clk);
        end
    end

    task automatic send_op(input t_in_item op, input logic pinned, input t_out_item want);
        int gap;
        gap = pick_wait(send_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pin_on   = pinned;
        pin_want = want;
        in_valid <= 1'b1;
        in_item  <= op;
        do @(posedge clk); while (!o_in_ready);
        @(negedge clk);
    endtask

    task automatic send_random(input logic kind);
        t_in_item op;
        op.kind  = kind;
        op.value = pick_value();
        send_op(op, 1'b0, '0);
    endtask

    task automatic run_mix(input int ops, input int insert_pct);
        for (int i = 0; i < ops; i++) begin
            send_random(($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_order(input logic min_first);
        drain_results();
        repeat (4) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= min_first;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        int fill;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (OP_ROWS[i]) begin
            send_op('{OP_ROWS[i].kind, OP_ROWS[i].value}, OP_ROWS[i].pinned, OP_ROWS[i].want);
        end

        set_order(1'b1);
        run_mix(300, 60);

        // fill to capacity, then hit the full case more than once
        set_order(1'b0);
        fill = CAPACITY - heap_count;
        repeat (fill) send_random(KIND_INSERT);
        repeat (4) send_random(KIND_INSERT);
        send_random(KIND_REMOVE);
        repeat (3) send_random(KIND_INSERT);

        set_order(1'b1);
        run_mix(380, 35);

        drain_results();
        repeat (20) @(posedge clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        repeat (LIMIT) @(posedge clk);
        $display("%0t: timeout, %0d transactions outstanding", $time, due_results.size());
        $display("tb: failure");
        $finish;
    end

endmodule
